@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/i2crm_pkg.sv @@
// package for the i2c register master: types, codes and constants
`timescale 1ns / 1ps

package i2crm_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int DEV_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 10;
    localparam int BIT_W   = 4;
    localparam int STEP_W  = 5;

    // longest transfer by default
    localparam int MAX_LENGTH_DEF = 255;

    // configuration reset values
    localparam logic [PHASE_W-1:0] PHASE_LEN_RST = 10'd1;
    localparam logic [BYTE_W-1:0]  ACK_LIMIT_RST = 8'd250;

    // configuration register indexes
    localparam logic CFG_PHASE_LEN = 1'b0;
    localparam logic CFG_ACK_LIMIT = 1'b1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // bus sequencer steps
    typedef enum logic [STEP_W-1:0] {
        ST_IDLE = 5'd0,
        ST_SA   = 5'd1,
        ST_SB   = 5'd2,
        ST_SC   = 5'd3,
        ST_SD   = 5'd4,
        ST_TA   = 5'd5,
        ST_TB   = 5'd6,
        ST_TC   = 5'd7,
        ST_AA   = 5'd8,
        ST_AB   = 5'd9,
        ST_AW   = 5'd10,
        ST_AC   = 5'd11,
        ST_RA   = 5'd12,
        ST_RB   = 5'd13,
        ST_MA   = 5'd14,
        ST_MB   = 5'd15,
        ST_MC   = 5'd16,
        ST_PA   = 5'd17,
        ST_PB   = 5'd18,
        ST_PC   = 5'd19
    } t_step;

    // which byte of the transfer is on the bus
    typedef enum logic [1:0] {
        STG_ADDR_W = 2'd0,
        STG_REG    = 2'd1,
        STG_ADDR_R = 2'd2,
        STG_DATA   = 2'd3
    } t_stage;

endpackage

@@ sv/i2c_register_master.sv @@
// i2c register master: tick-driven bus sequencer with a registered result
`timescale 1ns / 1ps
// Usage
//   Input channel (i_in_valid / o_in_stall): one beat is one timing tick with
//   a command, the transfer fields and the sampled SDA level. Command 1 starts
//   a register write, command 2 a register read; while busy they are ignored.
//   Output channel (o_out_valid / i_out_stall): one result beat per input beat
//   with SCL level, SDA pull-low, byte_taken, read data, finished and status.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0
//   sets ticks per phase, index 1 the ack wait limit. Write it while idle.
// Timing
//   Each beat is handled in the cycle it is accepted; its result appears in
//   the output register on the next cycle. One beat per cycle is sustained
//   while the receiver does not stall a held result, set by the single
//   sequencer update between the input handshake and the result register.
// Reset and stall
//   Synchronous reset returns the sequencer to idle and empties the result
//   register; the phase length goes to 1 and the ack limit to 250. While the
//   receiver stalls a held result, o_in_stall is raised and no beat is taken.
module i2c_register_master #(
    parameter int MAX_LENGTH = i2crm_pkg::MAX_LENGTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input beats
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [i2crm_pkg::CMD_W-1:0]        i_command,
    input  logic [i2crm_pkg::DEV_W-1:0]        i_device_address,
    input  logic [i2crm_pkg::BYTE_W-1:0]       i_register_address,
    input  logic [i2crm_pkg::BYTE_W-1:0]       i_byte_count,
    input  logic [i2crm_pkg::BYTE_W-1:0]       i_write_byte,
    input  logic                               i_sda_sample,
    // result beats
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_scl_level,
    output logic                               o_sda_pull_low,
    output logic                               o_byte_taken,
    output logic [i2crm_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                               o_read_valid,
    output logic                               o_finished,
    output logic                               o_status,
    output logic                               o_busy_res,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [i2crm_pkg::PHASE_W-1:0]      i_cfg_data
);
    import i2crm_pkg::*;

    localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_LENGTH);

    // configuration
    logic [PHASE_W-1:0] r_phase_length;
    logic [BYTE_W-1:0]  r_ack_wait_limit;

    // sequencer state
    t_step              r_step, n_step;
    t_stage             r_stage, n_stage;
    logic [PHASE_W-1:0] r_phase_ticks, n_phase_ticks;
    logic [BIT_W-1:0]   r_bit_index, n_bit_index;
    logic [BYTE_W-1:0]  r_shift, n_shift;
    logic [BYTE_W-1:0]  r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0]  r_ack_count, n_ack_count;
    logic [DEV_W-1:0]   r_dev, n_dev;
    logic [BYTE_W-1:0]  r_reg, n_reg;
    logic               r_read_mode, n_read_mode;
    logic               r_abort, n_abort;

    // result register
    logic               r_out_valid;
    logic               r_scl, n_scl;
    logic               r_pull, n_pull;
    logic               r_taken, n_taken;
    logic [BYTE_W-1:0]  r_rbyte, n_rbyte;
    logic               r_rvalid, n_rvalid;
    logic               r_fin, n_fin;
    logic               r_stat, n_stat;
    logic               r_busy, n_busy;

    logic               w_in_accept;
    logic               w_cfg_write;

    // handshakes
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_length   <= PHASE_LEN_RST;
            r_ack_wait_limit <= ACK_LIMIT_RST;
        end else if (w_cfg_write) begin
            case (i_cfg_index)
                CFG_PHASE_LEN: r_phase_length   <= i_cfg_data;
                CFG_ACK_LIMIT: r_ack_wait_limit <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // one sequencer tick: line levels and next state
    always_comb begin
        logic [PHASE_W-1:0] v_plen;
        logic [PHASE_W:0]   v_inc;
        logic               v_over;
        logic [BIT_W-1:0]   v_bits;
        logic [BYTE_W-1:0]  v_shift_tx;
        logic [BYTE_W-1:0]  v_shift_rx;
        logic [BYTE_W-1:0]  v_left_dec;
        logic               v_bit_low;
        logic               v_ack_low;

        n_step        = r_step;
        n_stage       = r_stage;
        n_phase_ticks = r_phase_ticks;
        n_bit_index   = r_bit_index;
        n_shift       = r_shift;
        n_bytes_left  = r_bytes_left;
        n_ack_count   = r_ack_count;
        n_dev         = r_dev;
        n_reg         = r_reg;
        n_read_mode   = r_read_mode;
        n_abort       = r_abort;

        n_scl    = 1'b1;
        n_pull   = 1'b0;
        n_taken  = 1'b0;
        n_rbyte  = '0;
        n_rvalid = 1'b0;
        n_fin    = 1'b0;
        n_stat   = 1'b0;
        n_busy   = 1'b0;

        v_plen = (r_phase_length == '0) ? PHASE_W'(1) : r_phase_length;

        // begin of a transfer, first START phase held on this tick
        if (r_step == ST_IDLE && (i_command == CMD_WRITE || i_command == CMD_READ)) begin
            n_dev         = i_device_address;
            n_reg         = i_register_address;
            n_bytes_left  = (i_byte_count > MAX_LEN) ? MAX_LEN : i_byte_count;
            n_read_mode   = (i_command == CMD_READ);
            n_stage       = STG_ADDR_W;
            n_abort       = 1'b0;
            n_ack_count   = '0;
            n_bit_index   = '0;
            n_shift       = '0;
            n_step        = ST_SA;
            n_phase_ticks = '0;
        end

        v_inc      = {1'b0, n_phase_ticks} + (PHASE_W+1)'(1);
        v_over     = (v_inc >= {1'b0, v_plen});
        v_bits     = n_bit_index + BIT_W'(1);
        v_shift_tx = {n_shift[BYTE_W-2:0], 1'b0};
        v_shift_rx = {n_shift[BYTE_W-2:0], i_sda_sample};
        v_left_dec = n_bytes_left - BYTE_W'(1);
        v_bit_low  = !n_shift[BYTE_W-1];
        v_ack_low  = (n_bytes_left > BYTE_W'(1));

        if (n_step != ST_IDLE) begin
            n_busy = 1'b1;

            // line levels of the current step
            case (n_step)
                ST_SA:                      begin n_scl = 1'b0; n_pull = 1'b0;      end
                ST_SB:                      begin n_scl = 1'b1; n_pull = 1'b0;      end
                ST_SC:                      begin n_scl = 1'b1; n_pull = 1'b1;      end
                ST_SD:                      begin n_scl = 1'b0; n_pull = 1'b1;      end
                ST_TA, ST_TC:               begin n_scl = 1'b0; n_pull = v_bit_low; end
                ST_TB:                      begin n_scl = 1'b1; n_pull = v_bit_low; end
                ST_AA, ST_AC, ST_RA:        begin n_scl = 1'b0; n_pull = 1'b0;      end
                ST_AB, ST_AW, ST_RB:        begin n_scl = 1'b1; n_pull = 1'b0;      end
                ST_MA, ST_MC:               begin n_scl = 1'b0; n_pull = v_ack_low; end
                ST_MB:                      begin n_scl = 1'b1; n_pull = v_ack_low; end
                ST_PA:                      begin n_scl = 1'b0; n_pull = 1'b1;      end
                ST_PB:                      begin n_scl = 1'b1; n_pull = 1'b1;      end
                default:                    begin n_scl = 1'b1; n_pull = 1'b0;      end
            endcase

            if (n_step == ST_AW) begin
                // ack slot: wait for the target to pull SDA low
                n_phase_ticks = '0;
                if (!i_sda_sample) begin
                    n_step = ST_AC;
                end else if (n_ack_count >= r_ack_wait_limit) begin
                    n_abort = 1'b1;
                    n_step  = ST_PA;
                end else begin
                    n_ack_count = n_ack_count + BYTE_W'(1);
                end
            end else if (v_over) begin
                n_phase_ticks = '0;
                case (n_step)
                    ST_SA: n_step = ST_SB;
                    ST_SB: n_step = ST_SC;
                    ST_SC: n_step = ST_SD;
                    ST_SD: begin
                        n_shift     = {n_dev, (n_stage == STG_ADDR_R)};
                        n_bit_index = '0;
                        n_step      = ST_TA;
                    end
                    ST_TA: n_step = ST_TB;
                    ST_TB: n_step = ST_TC;
                    ST_TC: begin
                        n_shift     = v_shift_tx;
                        n_bit_index = v_bits;
                        n_step      = (v_bits >= BIT_W'(8)) ? ST_AA : ST_TA;
                    end
                    ST_AA: n_step = ST_AB;
                    ST_AB: begin
                        n_ack_count = '0;
                        n_step      = ST_AW;
                    end
                    ST_AC: begin
                        // choose the next byte after an ack
                        case (n_stage)
                            STG_ADDR_W: begin
                                n_stage     = STG_REG;
                                n_shift     = n_reg;
                                n_bit_index = '0;
                                n_step      = ST_TA;
                            end
                            STG_REG: begin
                                if (n_read_mode) begin
                                    n_stage = STG_ADDR_R;
                                    n_step  = ST_SA;
                                end else if (n_bytes_left != '0) begin
                                    n_taken      = 1'b1;
                                    n_bytes_left = v_left_dec;
                                    n_stage      = STG_DATA;
                                    n_shift      = i_write_byte;
                                    n_bit_index  = '0;
                                    n_step       = ST_TA;
                                end else begin
                                    n_step = ST_PA;
                                end
                            end
                            STG_ADDR_R: begin
                                if (n_bytes_left != '0) begin
                                    n_shift     = '0;
                                    n_bit_index = '0;
                                    n_step      = ST_RA;
                                end else begin
                                    n_step = ST_PA;
                                end
                            end
                            default: begin
                                if (n_bytes_left != '0) begin
                                    n_taken      = 1'b1;
                                    n_bytes_left = v_left_dec;
                                    n_stage      = STG_DATA;
                                    n_shift      = i_write_byte;
                                    n_bit_index  = '0;
                                    n_step       = ST_TA;
                                end else begin
                                    n_step = ST_PA;
                                end
                            end
                        endcase
                    end
                    ST_RA: n_step = ST_RB;
                    ST_RB: begin
                        // sample a data bit at the end of SCL high
                        n_shift     = v_shift_rx;
                        n_bit_index = v_bits;
                        if (v_bits >= BIT_W'(8)) begin
                            n_rvalid = 1'b1;
                            n_rbyte  = v_shift_rx;
                            n_step   = ST_MA;
                        end else begin
                            n_step = ST_RA;
                        end
                    end
                    ST_MA: n_step = ST_MB;
                    ST_MB: n_step = ST_MC;
                    ST_MC: begin
                        n_bytes_left = v_left_dec;
                        if (v_left_dec != '0) begin
                            n_shift     = '0;
                            n_bit_index = '0;
                            n_step      = ST_RA;
                        end else begin
                            n_step = ST_PA;
                        end
                    end
                    ST_PA: n_step = ST_PB;
                    ST_PB: n_step = ST_PC;
                    default: begin
                        // end of STOP
                        n_fin   = 1'b1;
                        n_stat  = n_abort;
                        n_abort = 1'b0;
                        n_step  = ST_IDLE;
                    end
                endcase
            end else begin
                n_phase_ticks = v_inc[PHASE_W-1:0];
            end
        end
    end

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= ST_IDLE;
            r_stage       <= STG_ADDR_W;
            r_phase_ticks <= '0;
            r_bit_index   <= '0;
            r_shift       <= '0;
            r_bytes_left  <= '0;
            r_ack_count   <= '0;
            r_dev         <= '0;
            r_reg         <= '0;
            r_read_mode   <= 1'b0;
            r_abort       <= 1'b0;
        end else if (w_in_accept) begin
            r_step        <= n_step;
            r_stage       <= n_stage;
            r_phase_ticks <= n_phase_ticks;
            r_bit_index   <= n_bit_index;
            r_shift       <= n_shift;
            r_bytes_left  <= n_bytes_left;
            r_ack_count   <= n_ack_count;
            r_dev         <= n_dev;
            r_reg         <= n_reg;
            r_read_mode   <= n_read_mode;
            r_abort       <= n_abort;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_scl    <= n_scl;
            r_pull   <= n_pull;
            r_taken  <= n_taken;
            r_rbyte  <= n_rbyte;
            r_rvalid <= n_rvalid;
            r_fin    <= n_fin;
            r_stat   <= n_stat;
            r_busy   <= n_busy;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_level    = r_scl;
    assign o_sda_pull_low = r_pull;
    assign o_byte_taken   = r_taken;
    assign o_read_byte    = r_rbyte;
    assign o_read_valid   = r_rvalid;
    assign o_finished     = r_fin;
    assign o_status       = r_stat;
    assign o_busy_res     = r_busy;

endmodule

@@ sv/i2crm_checker.sv @@
// port-level checker for the i2c register master, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2crm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_scl_level,
    input logic       o_byte_taken,
    input logic       o_read_valid,
    input logic       o_finished,
    input logic       o_status,
    input logic       o_busy_res
);

    // a held result beat stays valid
    `CHK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result beat dropped while stalled")

    // an abort status only comes with the end of STOP
    `CHK_IMPLY(a_status_fin, o_out_valid && o_status, o_finished, "status without finish")

    // finish and read data only inside a transaction
    `CHK_IMPLY(a_fin_busy, o_out_valid && (o_finished || o_read_valid), o_busy_res, "event while idle")

    // a write byte is taken only with SCL low
    `CHK_IMPLY(a_taken_scl, o_out_valid && o_byte_taken, !o_scl_level, "byte taken with SCL high")

    // a read byte completes at the end of SCL high
    `CHK_IMPLY(a_read_scl, o_out_valid && o_read_valid, o_scl_level, "read byte with SCL low")

endmodule

bind i2c_register_master i2crm_checker u_i2crm_checker (.*);

@@ bench/i2c_register_master_test.sv @@
// self-checking bench for the i2c register master: tick stimulus, line prediction, result check
`timescale 1ns / 1ps

module i2c_register_master_test;
    import i2crm_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int unsigned RUN_LIMIT_NS = 50_000_000;
    localparam int          LONG_HOLD    = 60;
    localparam int          DRAIN_LIMIT  = 2000;
    localparam int          PRINT_LIMIT  = 40;
    // command code the block treats as a plain tick
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one input beat: a timing tick
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DEV_W-1:0]  device;
        logic [BYTE_W-1:0] regad;
        logic [BYTE_W-1:0] count;
        logic [BYTE_W-1:0] wbyte;
        logic              sda;
    } t_tick;

    // one result beat: bus lines and transfer status
    typedef struct packed {
        logic              scl;
        logic              pull;
        logic              taken;
        logic [BYTE_W-1:0] rbyte;
        logic              rvalid;
        logic              fin;
        logic              status;
        logic              busy;
    } t_lines;

    // shadow sequencer and queue of expected line beats
    class t_bus_line_board;
        logic [PHASE_W-1:0] plen;
        logic [BYTE_W-1:0]  limit;
        t_step              step;
        int                 ticks;
        logic [BIT_W-1:0]   bit_idx;
        logic [BYTE_W-1:0]  shreg;
        logic [BYTE_W-1:0]  left;
        logic [BYTE_W-1:0]  ack_cnt;
        logic [DEV_W-1:0]   dev;
        logic [BYTE_W-1:0]  regad;
        logic               rd_mode;
        t_stage             stage;
        logic               aborting;
        t_lines             expected_lines[$];
        int                 mismatches;
        int                 checked;
        int                 transfers;
        int                 timeouts;
        int                 bytes_read;

        function new();
            plen       = PHASE_LEN_RST;
            limit      = ACK_LIMIT_RST;
            step       = ST_IDLE;
            ticks      = 0;
            bit_idx    = '0;
            shreg      = '0;
            left       = '0;
            ack_cnt    = '0;
            dev        = '0;
            regad      = '0;
            rd_mode    = 1'b0;
            stage      = STG_ADDR_W;
            aborting   = 1'b0;
            mismatches = 0;
            checked    = 0;
            transfers  = 0;
            timeouts   = 0;
            bytes_read = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) $display("mismatch: %s", msg);
        endfunction

        function int waiting();
            return expected_lines.size();
        endfunction

        function void go(t_step s);
            step  = s;
            ticks = 0;
        endfunction

        // true on the last tick of a phase; zero length counts as one
        function bit phase_done();
            int len;
            len = (plen == '0) ? 1 : int'(plen);
            if (ticks + 1 >= len) begin
                ticks = 0;
                return 1'b1;
            end
            ticks = (ticks + 1) & 'h3FF;
            return 1'b0;
        endfunction

        function void load_byte(logic [BYTE_W-1:0] value);
            shreg   = value;
            bit_idx = '0;
            go(ST_TA);
        endfunction

        // next move once a byte was acknowledged; returns 1 when a write byte is consumed
        function logic ack_done(logic [BYTE_W-1:0] wb);
            logic took;
            took = 1'b0;
            case (stage)
                STG_ADDR_W: begin
                    stage = STG_REG;
                    load_byte(regad);
                end
                STG_REG: begin
                    if (rd_mode) begin
                        stage = STG_ADDR_R;
                        go(ST_SA);
                    end else if (left != '0) begin
                        took = 1'b1;
                    end else begin
                        go(ST_PA);
                    end
                end
                STG_ADDR_R: begin
                    if (left != '0) begin
                        shreg   = '0;
                        bit_idx = '0;
                        go(ST_RA);
                    end else begin
                        go(ST_PA);
                    end
                end
                default: begin
                    if (left != '0) took = 1'b1;
                    else go(ST_PA);
                end
            endcase
            if (took) begin
                left  = left - 1'b1;
                stage = STG_DATA;
                load_byte(wb);
            end
            return took;
        endfunction

        // advance one tick and queue the line levels it should produce
        function void note_tick(t_tick t);
            t_lines o;
            t_step  s;
            o     = '0;
            o.scl = 1'b1;
            if (step == ST_IDLE && (t.command == CMD_WRITE || t.command == CMD_READ)) begin
                dev      = t.device;
                regad    = t.regad;
                left     = (t.count > MAX_LENGTH_DEF) ? BYTE_W'(MAX_LENGTH_DEF) : t.count;
                rd_mode  = (t.command == CMD_READ);
                stage    = STG_ADDR_W;
                aborting = 1'b0;
                ack_cnt  = '0;
                bit_idx  = '0;
                shreg    = '0;
                go(ST_SA);
                transfers++;
            end
            s = step;
            if (s != ST_IDLE) begin
                o.busy = 1'b1;
                // line levels held during this step
                case (s)
                    ST_SA:                begin o.scl = 1'b0; o.pull = 1'b0; end
                    ST_SB:                begin o.scl = 1'b1; o.pull = 1'b0; end
                    ST_SC:                begin o.scl = 1'b1; o.pull = 1'b1; end
                    ST_SD:                begin o.scl = 1'b0; o.pull = 1'b1; end
                    ST_TA, ST_TC:         begin o.scl = 1'b0; o.pull = ~shreg[7]; end
                    ST_TB:                begin o.scl = 1'b1; o.pull = ~shreg[7]; end
                    ST_AA, ST_AC, ST_RA:  begin o.scl = 1'b0; o.pull = 1'b0; end
                    ST_AB, ST_AW, ST_RB:  begin o.scl = 1'b1; o.pull = 1'b0; end
                    ST_MA, ST_MC:         begin o.scl = 1'b0; o.pull = (left > 1); end
                    ST_MB:                begin o.scl = 1'b1; o.pull = (left > 1); end
                    ST_PA:                begin o.scl = 1'b0; o.pull = 1'b1; end
                    ST_PB:                begin o.scl = 1'b1; o.pull = 1'b1; end
                    default:              begin o.scl = 1'b1; o.pull = 1'b0; end
                endcase
                // ack slot samples every tick, other steps move on phase end
                if (s == ST_AW) begin
                    if (!t.sda) begin
                        go(ST_AC);
                    end else if (ack_cnt >= limit) begin
                        aborting = 1'b1;
                        go(ST_PA);
                    end else begin
                        ack_cnt = ack_cnt + 1'b1;
                    end
                end else if (phase_done()) begin
                    case (s)
                        ST_SA: go(ST_SB);
                        ST_SB: go(ST_SC);
                        ST_SC: go(ST_SD);
                        ST_SD: load_byte({dev, stage == STG_ADDR_R});
                        ST_TA: go(ST_TB);
                        ST_TB: go(ST_TC);
                        ST_TC: begin
                            shreg   = {shreg[6:0], 1'b0};
                            bit_idx = bit_idx + 1'b1;
                            if (bit_idx >= 8) go(ST_AA);
                            else go(ST_TA);
                        end
                        ST_AA: go(ST_AB);
                        ST_AB: begin
                            ack_cnt = '0;
                            go(ST_AW);
                        end
                        ST_AC: o.taken = ack_done(t.wbyte);
                        ST_RA: go(ST_RB);
                        ST_RB: begin
                            shreg   = {shreg[6:0], t.sda};
                            bit_idx = bit_idx + 1'b1;
                            if (bit_idx >= 8) begin
                                o.rvalid = 1'b1;
                                o.rbyte  = shreg;
                                bytes_read++;
                                go(ST_MA);
                            end else begin
                                go(ST_RA);
                            end
                        end
                        ST_MA: go(ST_MB);
                        ST_MB: go(ST_MC);
                        ST_MC: begin
                            left = left - 1'b1;
                            if (left != '0) begin
                                shreg   = '0;
                                bit_idx = '0;
                                go(ST_RA);
                            end else begin
                                go(ST_PA);
                            end
                        end
                        ST_PA: go(ST_PB);
                        ST_PB: go(ST_PC);
                        default: begin
                            o.fin    = 1'b1;
                            o.status = aborting;
                            if (aborting) timeouts++;
                            aborting = 1'b0;
                            go(ST_IDLE);
                        end
                    endcase
                end
            end
            expected_lines.push_back(o);
        endfunction

        // compare one result beat against the oldest expected one
        function void check_lines(t_lines got);
            t_lines w;
            if (expected_lines.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            w = expected_lines.pop_front();
            checked++;
            if (got.scl !== w.scl)
                report($sformatf("beat %0d scl_level %b want %b", checked, got.scl, w.scl));
            if (got.pull !== w.pull)
                report($sformatf("beat %0d sda_pull_low %b want %b", checked, got.pull, w.pull));
            if (got.taken !== w.taken)
                report($sformatf("beat %0d byte_taken %b want %b", checked, got.taken, w.taken));
            if (got.rbyte !== w.rbyte)
                report($sformatf("beat %0d read_byte %h want %h", checked, got.rbyte, w.rbyte));
            if (got.rvalid !== w.rvalid)
                report($sformatf("beat %0d read_valid %b want %b", checked, got.rvalid, w.rvalid));
            if (got.fin !== w.fin)
                report($sformatf("beat %0d finished %b want %b", checked, got.fin, w.fin));
            if (got.status !== w.status)
                report($sformatf("beat %0d status %b want %b", checked, got.status, w.status));
            if (got.busy !== w.busy)
                report($sformatf("beat %0d busy_res %b want %b", checked, got.busy, w.busy));
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command;
    logic [DEV_W-1:0]    i_device_address;
    logic [BYTE_W-1:0]   i_register_address;
    logic [BYTE_W-1:0]   i_byte_count;
    logic [BYTE_W-1:0]   i_write_byte;
    logic                i_sda_sample;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_scl_level;
    logic                o_sda_pull_low;
    logic                o_byte_taken;
    logic [BYTE_W-1:0]   o_read_byte;
    logic                o_read_valid;
    logic                o_finished;
    logic                o_status;
    logic                o_busy_res;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [PHASE_W-1:0]  i_cfg_data;

    t_bus_line_board board;

    // sender and receiver control
    bit quiet         = 1'b0;
    bit long_hold_req = 1'b0;
    bit offering      = 1'b0;
    int ticks_sent    = 0;

    // slave behavior in ack slots for the running transfer
    int stubborn_slot = -1;
    int ack_dmax      = 0;
    int slot_no       = -1;
    bit in_slot       = 1'b0;
    int slot_delay    = 0;
    int slot_highs    = 0;

    i2c_register_master u_top (.*);

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // result beat check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_lines({o_scl_level, o_sda_pull_low, o_byte_taken, o_read_byte,
                               o_read_valid, o_finished, o_status, o_busy_res});
    end

    // receiver stall bursts and the long hold-off
    initial begin : stall_gen
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(1, 10);
            end
            i_out_stall <= (hold_left > 0);
        end
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_tick random_fields();
        t_tick t;
        t.command = CMD_TICK;
        t.device  = 7'($urandom);
        t.regad   = 8'($urandom);
        t.count   = 8'($urandom);
        t.wbyte   = 8'($urandom);
        t.sda     = 1'($urandom);
        return t;
    endfunction

    // tick while a transfer runs: stray commands, slave ack and read data
    function automatic t_tick busy_tick();
        t_tick t;
        t = random_fields();
        case ($urandom_range(0, 15))
            0:       t.command = CMD_UNUSED;
            1:       t.command = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            default: t.command = CMD_TICK;
        endcase
        if (board.step == ST_AW) begin
            if (!in_slot) begin
                in_slot    = 1'b1;
                slot_no++;
                slot_delay = $urandom_range(0, ack_dmax);
                slot_highs = 0;
            end
            if (slot_no == stubborn_slot || slot_highs < slot_delay) begin
                t.sda = 1'b1;
                slot_highs++;
            end else begin
                t.sda = 1'b0;
            end
        end else begin
            in_slot = 1'b0;
        end
        return t;
    endfunction

    task automatic send_tick(t_tick t);
        i_in_valid         <= 1'b1;
        i_command          <= t.command;
        i_device_address   <= t.device;
        i_register_address <= t.regad;
        i_byte_count       <= t.count;
        i_write_byte       <= t.wbyte;
        i_sda_sample       <= t.sda;
        offering = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        board.note_tick(t);
        ticks_sent++;
    endtask

    task automatic stop_offering();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 11) == 0) begin
            stop_offering();
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic drain_pause();
        stop_offering();
        while (board.waiting() != 0) @(posedge i_clk);
    endtask

    // write both timing registers with the sequencer idle
    task automatic set_timing(logic [PHASE_W-1:0] plen, logic [BYTE_W-1:0] limit);
        drain_pause();
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PHASE_LEN;
        i_cfg_data  <= plen;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.plen = plen;
        i_cfg_index <= CFG_ACK_LIMIT;
        i_cfg_data  <= {2'b00, limit};
        do @(posedge i_clk); while (!o_cfg_ready);
        board.limit = limit;
        i_cfg_valid <= 1'b0;
    endtask

    // one whole transfer: begin beat, then ticks until the sequencer is idle again
    task automatic do_transfer(logic [CMD_W-1:0] cmd, logic [DEV_W-1:0] dev,
                               logic [BYTE_W-1:0] regad, logic [BYTE_W-1:0] count,
                               int stub, int dmax);
        t_tick t;
        stubborn_slot = stub;
        ack_dmax      = dmax;
        slot_no       = -1;
        in_slot       = 1'b0;
        t         = random_fields();
        t.command = cmd;
        t.device  = dev;
        t.regad   = regad;
        t.count   = count;
        send_tick(t);
        maybe_gap();
        while (board.step != ST_IDLE) begin
            send_tick(busy_tick());
            maybe_gap();
        end
    endtask

    // random transfers and idle ticks until the tick budget is spent
    task automatic random_transfers(int budget);
        int               start;
        bit               paused;
        int               n;
        int               stub;
        logic [BYTE_W-1:0] count;
        t_tick            t;
        start  = ticks_sent;
        paused = 1'b0;
        if (!quiet) long_hold_req = 1'b1;
        while (ticks_sent - start < budget) begin
            if ($urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    t = random_fields();
                    if ($urandom_range(0, 1)) t.command = CMD_UNUSED;
                    send_tick(t);
                    maybe_gap();
                end
            end else begin
                n    = $urandom_range(0, 9);
                stub = -1;
                if ($urandom_range(0, 7) == 0) stub = $urandom_range(0, 3);
                if (n < 7) begin
                    count = 8'($urandom_range(0, 3));
                end else if (n < 9) begin
                    count = 8'($urandom_range(4, 6));
                end else begin
                    // long counts end early on a stuck ack
                    count = 8'($urandom_range(7, 255));
                    stub  = $urandom_range(0, 2);
                end
                do_transfer($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 7'($urandom),
                            8'($urandom), count, stub, $urandom_range(0, 4));
            end
            if (!paused && ticks_sent - start >= budget / 2) begin
                drain_pause();
                paused = 1'b1;
            end
        end
    endtask

    // main sequence
    initial begin : main
        t_tick t;
        int    n;
        board              = new();
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_command          = CMD_TICK;
        i_device_address   = '0;
        i_register_address = '0;
        i_byte_count       = '0;
        i_write_byte       = '0;
        i_sda_sample       = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = CFG_PHASE_LEN;
        i_cfg_data         = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed transfers at reset timing
        do_transfer(CMD_WRITE, 7'h7F, 8'hFF, 8'd2, -1, 0);
        do_transfer(CMD_WRITE, 7'h00, 8'h00, 8'd1, -1, 3);
        do_transfer(CMD_READ,  7'h55, 8'hAA, 8'd3, -1, 2);
        do_transfer(CMD_READ,  7'h2A, 8'h55, 8'd0, -1, 1);
        do_transfer(CMD_WRITE, 7'h01, 8'h80, 8'd0, -1, 0);
        repeat (5) begin
            t         = random_fields();
            t.command = CMD_UNUSED;
            send_tick(t);
            maybe_gap();
        end
        // timeout on address+W at the reset ack limit
        do_transfer(CMD_READ,  7'h12, 8'h34, 8'd1, 0, 0);

        // zero phase length and zero ack limit
        set_timing(10'd0, 8'd0);
        random_transfers(100);
        set_timing(10'd3, 8'd5);
        random_transfers(120);
        set_timing(10'd2, 8'd255);
        random_transfers(80);
        set_timing(10'd1, 8'd3);
        quiet = 1'b1;
        random_transfers(150);

        // drain and let the output register settle
        stop_offering();
        for (n = 0; n < DRAIN_LIMIT && board.waiting() != 0; n++) @(posedge i_clk);
        if (board.waiting() != 0)
            board.report($sformatf("%0d result beats never arrived", board.waiting()));
        repeat (4) @(posedge i_clk);

        $display("run: %0d ticks, %0d transfers begun, %0d ended by ack timeout, %0d bytes read",
                 ticks_sent, board.transfers, board.timeouts, board.bytes_read);
        $display("run: phase lengths 0 to 3, ack limits 0 to 255, %0d result beats checked",
                 board.checked);
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
